@@ hdl/hcbd_pkg.sv @@
package hcbd_pkg;

	localparam int CAP_W = 24;
	localparam logic [CAP_W-1:0] CAP_RESET = 24'd4096;

	localparam logic [7:0] CH_CR = 8'h0D;
	localparam logic [7:0] CH_LF = 8'h0A;
	localparam logic [7:0] CH_SP = 8'h20;
	localparam logic [7:0] CH_TAB = 8'h09;

	typedef enum logic [2:0] {
		PH_HDR   = 3'd0,
		PH_SIZE  = 3'd1,
		PH_LINE  = 3'd2,
		PH_DATA  = 3'd3,
		PH_TRAIL = 3'd4,
		PH_IDLE  = 3'd5
	} phase_t;

	typedef enum logic [1:0] {
		K_BYTE = 2'd0,
		K_DONE = 2'd1,
		K_BAD  = 2'd2,
		K_BIG  = 2'd3
	} kind_t;

	typedef struct packed {
		logic       ok;
		logic [3:0] val;
	} hex_t;

	function automatic hex_t hex_decode(input logic [7:0] b);
		hex_t h;
		h.ok = 1'b1;
		h.val = 4'd0;
		if (b >= 8'h30 && b <= 8'h39) begin
			h.val = 4'(b - 8'h30);
		end else if (b >= 8'h61 && b <= 8'h66) begin
			h.val = 4'(b - 8'h57);
		end else if (b >= 8'h41 && b <= 8'h46) begin
			h.val = 4'(b - 8'h37);
		end else begin
			h.ok = 1'b0;
		end
		return h;
	endfunction

	function automatic logic is_ws(input logic [7:0] b);
		return (b == CH_SP) || (b >= CH_TAB && b <= CH_CR);
	endfunction

endpackage

@@ hdl/http_chunked_body_decoder_unit.sv @@
// channel   direction  handshake               payload
// resp      in         resp_valid/resp_stall   resp_byte, resp_last
// res       out        res_valid/res_stall     kind, body_byte
// cfg       in         cfg_valid/cfg_ready     body_capacity
//
// one byte per cycle while no result is held by res_stall; an accepted byte sits in the input register
// and its result is loaded into the result register when that register advances, zero or one result per byte
// arst_n clears all control state and sets the capacity to 4096
// res_stall holds the result register while it is valid, and the input register behind it;
// resp_stall rises only while the input register holds a byte that cannot move
module http_chunked_body_decoder_unit #(
	parameter int COUNT_BITS = 24
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      resp_valid,
	output logic                      resp_stall,
	input  logic [7:0]                resp_byte,
	input  logic                      resp_last,
	output logic                      res_valid,
	input  logic                      res_stall,
	output hcbd_pkg::kind_t           kind,
	output logic [7:0]                body_byte,
	input  logic                      cfg_valid,
	output logic                      cfg_ready,
	input  logic [hcbd_pkg::CAP_W-1:0] body_capacity
);
	import hcbd_pkg::*;

	localparam int TOT_W = (COUNT_BITS > CAP_W) ? COUNT_BITS : CAP_W;
	localparam int CMP_W = TOT_W + 1;

	logic                  valid_s1;
	logic [7:0]            byte_s1;
	logic                  last_s1;

	logic [CAP_W-1:0]      cap_q;
	phase_t                phase_q, phase_n;
	logic [1:0]            match_q, match_n;
	logic [COUNT_BITS-1:0] chunk_q, chunk_n;
	logic [COUNT_BITS-1:0] left_q, left_n;
	logic [TOT_W-1:0]      total_q, total_n;
	logic                  digit_q, digit_n;
	logic                  cr_q, cr_n;

	logic                  res_valid_q;
	kind_t                 kind_q;
	logic [7:0]            body_byte_q;

	logic                  adv;
	logic                  emit;
	kind_t                 ekind;
	logic                  hit;
	hex_t                  hx;
	logic [7:0]            hdr_chr;
	logic [CMP_W-1:0]      cap_x;
	logic [CMP_W-1:0]      sum_x;
	logic                  total_big;

	assign adv = !res_valid_q || !res_stall;
	assign resp_stall = valid_s1 && !adv;
	assign cfg_ready = 1'b1;
	assign res_valid = res_valid_q;
	assign kind = kind_q;
	assign body_byte = body_byte_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!resp_stall) begin
			valid_s1 <= resp_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (resp_valid && !resp_stall) begin
			byte_s1 <= resp_byte;
			last_s1 <= resp_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= CAP_RESET;
		end else if (cfg_valid && cfg_ready) begin
			cap_q <= body_capacity;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HDR;
			match_q <= '0;
			chunk_q <= '0;
			left_q <= '0;
			total_q <= '0;
			digit_q <= 1'b0;
			cr_q <= 1'b0;
		end else if (valid_s1 && adv) begin
			phase_q <= phase_n;
			match_q <= match_n;
			chunk_q <= chunk_n;
			left_q <= left_n;
			total_q <= total_n;
			digit_q <= digit_n;
			cr_q <= cr_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (adv) begin
			res_valid_q <= valid_s1 && emit;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && valid_s1 && emit) begin
			kind_q <= ekind;
			body_byte_q <= (ekind == K_BYTE) ? byte_s1 : 8'd0;
		end
	end

	assign cap_x = CMP_W'(cap_q);
	assign sum_x = CMP_W'(total_q) + CMP_W'(chunk_q);
	assign total_big = CMP_W'(total_q) >= cap_x;
	assign hx = hex_decode(byte_s1);
	assign hdr_chr = match_q[0] ? CH_LF : CH_CR;
	assign hit = cr_q && (byte_s1 == CH_LF);

	always_comb begin
		phase_n = phase_q;
		match_n = match_q;
		chunk_n = chunk_q;
		left_n = left_q;
		total_n = total_q;
		digit_n = digit_q;
		cr_n = cr_q;
		emit = 1'b0;
		ekind = K_BYTE;
		unique case (phase_q)
			PH_HDR: begin
				if (byte_s1 == hdr_chr) begin
					if (match_q == 2'd3) begin
						match_n = '0;
						phase_n = PH_SIZE;
						digit_n = 1'b0;
						chunk_n = '0;
					end else begin
						match_n = match_q + 2'd1;
					end
				end else begin
					match_n = {1'b0, byte_s1 == CH_CR};
				end
			end
			PH_SIZE: begin
				if (!digit_q && is_ws(byte_s1)) begin
					phase_n = PH_SIZE;
				end else if (hx.ok) begin
					digit_n = 1'b1;
					if (chunk_q[COUNT_BITS-1 -: 4] != 4'd0) begin
						chunk_n = '1;
					end else begin
						chunk_n = {chunk_q[COUNT_BITS-5:0], hx.val};
					end
				end else if (chunk_q == '0) begin
					phase_n = PH_IDLE;
					emit = 1'b1;
					ekind = total_big ? K_BIG : K_DONE;
				end else begin
					phase_n = PH_LINE;
					cr_n = (byte_s1 == CH_CR);
				end
			end
			PH_LINE: begin
				cr_n = (byte_s1 == CH_CR);
				if (hit) begin
					if (sum_x >= cap_x) begin
						phase_n = PH_IDLE;
						emit = 1'b1;
						ekind = K_BIG;
					end else begin
						left_n = chunk_q;
						phase_n = PH_DATA;
					end
				end
			end
			PH_DATA: begin
				if (!last_s1) begin
					emit = 1'b1;
					ekind = K_BYTE;
					total_n = total_q + TOT_W'(1);
					left_n = left_q - COUNT_BITS'(1);
					if (left_q == COUNT_BITS'(1)) begin
						phase_n = PH_TRAIL;
						cr_n = 1'b0;
					end
				end
			end
			PH_TRAIL: begin
				cr_n = (byte_s1 == CH_CR);
				if (hit) begin
					phase_n = PH_SIZE;
					digit_n = 1'b0;
					chunk_n = '0;
				end
			end
			default: begin
				phase_n = phase_q;
			end
		endcase

		if (last_s1) begin
			if (!emit && phase_n != PH_IDLE) begin
				emit = 1'b1;
				if (phase_n == PH_SIZE && digit_n && chunk_n == '0) begin
					ekind = (CMP_W'(total_n) >= cap_x) ? K_BIG : K_DONE;
				end else begin
					ekind = K_BAD;
				end
			end
			phase_n = PH_HDR;
			match_n = '0;
			chunk_n = '0;
			left_n = '0;
			total_n = '0;
			digit_n = 1'b0;
			cr_n = 1'b0;
		end
	end

	a_data_left: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_DATA |-> left_q != '0)
		else $error("data phase with nothing left");

	a_byte_zero: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && kind != K_BYTE |-> body_byte == 8'd0)
		else $error("status result carries a byte");

	a_stall_src: assert property (@(posedge clk) disable iff (!arst_n)
		resp_stall |-> valid_s1 && res_valid_q && res_stall)
		else $error("input stalled without a blocked result");

endmodule

@@ test/testbench.sv @@
import hcbd_pkg::*;

typedef struct packed {
	kind_t      kind;
	logic [7:0] data;
} body_result_t;

class chunked_body_tracker;
	body_result_t awaited[$];
	logic [23:0]  capacity;
	phase_t       stage;
	logic [1:0]   hdr_pos;
	logic [23:0]  size_acc;
	logic [23:0]  remaining;
	logic [23:0]  total;
	bit           digit_got;
	bit           cr_got;
	int           fail_count;

	function new();
		capacity = CAP_RESET;
		fail_count = 0;
		rearm();
	endfunction

	function void rearm();
		stage = PH_HDR;
		hdr_pos = 2'd0;
		size_acc = '0;
		remaining = '0;
		total = '0;
		digit_got = 0;
		cr_got = 0;
	endfunction

	function bit crlf_hit(logic [7:0] b);
		bit hit;
		hit = cr_got && b == CH_LF;
		cr_got = (b == CH_CR);
		return hit;
	endfunction

	// size line byte; returns 1 when the new chunk would not fit
	function bit size_line_step(logic [7:0] b);
		if (!crlf_hit(b))
			return 0;
		if (32'(total) + 32'(size_acc) >= 32'(capacity)) begin
			stage = PH_IDLE;
			return 1;
		end
		remaining = size_acc;
		stage = PH_DATA;
		return 0;
	endfunction

	function void note_byte(logic [7:0] b, bit last);
		bit           made;
		body_result_t r;
		int           hv;
		longint       grown;
		made = 0;
		r.kind = K_BYTE;
		r.data = 8'h00;
		hv = -1;
		if (b >= 8'h30 && b <= 8'h39)
			hv = b - 8'h30;
		else if (b >= 8'h61 && b <= 8'h66)
			hv = b - 8'h61 + 10;
		else if (b >= 8'h41 && b <= 8'h46)
			hv = b - 8'h41 + 10;
		case (stage)
			PH_HDR: begin
				if (b == (hdr_pos[0] ? CH_LF : CH_CR)) begin
					if (hdr_pos == 2'd3) begin
						hdr_pos = 2'd0;
						stage = PH_SIZE;
						digit_got = 0;
						size_acc = '0;
					end else begin
						hdr_pos++;
					end
				end else begin
					hdr_pos = (b == CH_CR) ? 2'd1 : 2'd0;
				end
			end
			PH_SIZE: begin
				if (!digit_got && (b == CH_SP || (b >= CH_TAB && b <= CH_CR))) begin
				end else if (hv >= 0) begin
					digit_got = 1;
					grown = longint'(size_acc) * 16 + hv;
					size_acc = (grown > 64'hFFFFFF) ? 24'hFFFFFF : grown[23:0];
				end else if (size_acc == 0) begin
					made = 1;
					r.kind = (total >= capacity) ? K_BIG : K_DONE;
					stage = PH_IDLE;
				end else begin
					stage = PH_LINE;
					cr_got = 0;
					if (size_line_step(b)) begin
						made = 1;
						r.kind = K_BIG;
					end
				end
			end
			PH_LINE: begin
				if (size_line_step(b)) begin
					made = 1;
					r.kind = K_BIG;
				end
			end
			PH_DATA: begin
				if (!last) begin
					made = 1;
					r.data = b;
					total++;
					remaining--;
					if (remaining == 0) begin
						stage = PH_TRAIL;
						cr_got = 0;
					end
				end
			end
			PH_TRAIL: begin
				if (crlf_hit(b)) begin
					stage = PH_SIZE;
					digit_got = 0;
					size_acc = '0;
				end
			end
			default: begin
			end
		endcase
		if (last) begin
			if (!made && stage != PH_IDLE) begin
				made = 1;
				// a zero size cut off by the end of the response still closes the body
				if (stage == PH_SIZE && digit_got && size_acc == 0)
					r.kind = (total >= capacity) ? K_BIG : K_DONE;
				else
					r.kind = K_BAD;
			end
			rearm();
		end
		if (made)
			awaited.push_back(r);
	endfunction

	task report(string what);
		fail_count++;
		if (fail_count <= 100)
			$display("mismatch %0d: %s", fail_count, what);
	endtask

	task check_result(kind_t k, logic [7:0] d);
		body_result_t w;
		if (awaited.size() == 0) begin
			report($sformatf("result with nothing awaited: kind %0d byte %02h", k, d));
			return;
		end
		w = awaited.pop_front();
		if (k !== w.kind)
			report($sformatf("kind %0d, awaited %0d", k, w.kind));
		if (d !== w.data)
			report($sformatf("body byte %02h, awaited %02h", d, w.data));
	endtask
endclass

module testbench;
	localparam int CYCLE_LIMIT = 400000;
	localparam int PHASE_BYTES = 175;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        resp_valid = 1'b0;
	logic        resp_stall;
	logic [7:0]  resp_byte = 8'h00;
	logic        resp_last = 1'b0;
	logic        res_valid;
	logic        res_stall = 1'b0;
	kind_t       res_kind;
	logic [7:0]  res_byte;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [23:0] cap_value = 24'd0;

	chunked_body_tracker tracker;
	logic [7:0]          msg[$];
	bit                  calm = 0;
	int                  sent_count = 0;
	int                  cycle_count = 0;

	http_chunked_body_decoder_unit dut (
		.clk(clk),
		.arst_n(arst_n),
		.resp_valid(resp_valid),
		.resp_stall(resp_stall),
		.resp_byte(resp_byte),
		.resp_last(resp_last),
		.res_valid(res_valid),
		.res_stall(res_stall),
		.kind(res_kind),
		.body_byte(res_byte),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.body_capacity(cap_value)
	);

	initial forever #10 clk = ~clk;

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("http_chunked_body_decoder_unit verification failed");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n && res_valid && !res_stall)
			tracker.check_result(res_kind, res_byte);
		res_stall <= !calm && ($urandom_range(0, 99) < 11);
	end

	task automatic send_byte(input logic [7:0] b, input logic l);
		while (!calm && $urandom_range(0, 99) < 11) begin
			resp_valid <= 1'b0;
			@(posedge clk);
		end
		resp_valid <= 1'b1;
		resp_byte <= b;
		resp_last <= l;
		do @(posedge clk); while (resp_stall);
		tracker.note_byte(b, l);
		sent_count++;
	endtask

	task automatic send_message();
		foreach (msg[i])
			send_byte(msg[i], i == msg.size() - 1);
	endtask

	task automatic wait_drained();
		while (tracker.awaited.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_capacity(input logic [23:0] v);
		cfg_valid <= 1'b1;
		cap_value <= v;
		do @(posedge clk); while (!cfg_ready);
		tracker.capacity = v;
		cfg_valid <= 1'b0;
	endtask

	function automatic void add_text(string s);
		for (int i = 0; i < s.len(); i++)
			msg.push_back(s[i]);
	endfunction

	function automatic void add_crlf();
		msg.push_back(CH_CR);
		msg.push_back(CH_LF);
	endfunction

	function automatic void add_size(int unsigned v);
		string s;
		s = $sformatf("%0h", v);
		if ($urandom_range(0, 1))
			s = s.toupper();
		if ($urandom_range(0, 5) == 0)
			s = {"0", s};
		add_text(s);
	endfunction

	// mostly well-formed responses with random content, some noise and truncation
	function automatic void make_message();
		int          n_chunks;
		int          sz;
		int          cut;
		logic [7:0]  w;
		msg.delete();
		if ($urandom_range(0, 99) < 10) begin
			repeat ($urandom_range(1, 16)) msg.push_back(8'($urandom));
			return;
		end
		repeat ($urandom_range(0, 5)) msg.push_back(8'($urandom_range(8'h21, 8'h7E)));
		if ($urandom_range(0, 4) == 0) begin
			add_crlf();
			msg.push_back(CH_CR);
		end
		add_crlf();
		add_crlf();
		n_chunks = $urandom_range(1, 3);
		for (int c = 0; c < n_chunks; c++) begin
			if ($urandom_range(0, 3) == 0) begin
				repeat ($urandom_range(1, 2)) begin
					w = 8'($urandom_range(8'h08, 8'h0D));
					msg.push_back(w == 8'h08 ? CH_SP : w);
				end
			end
			sz = ($urandom_range(0, 19) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
			if ($urandom_range(0, 29) == 0)
				add_text("fffffff");
			else
				add_size(sz);
			if ($urandom_range(0, 4) == 0)
				add_text(";ext=1");
			add_crlf();
			repeat (sz) msg.push_back(8'($urandom));
			if ($urandom_range(0, 4) == 0)
				msg.push_back(8'($urandom));
			add_crlf();
		end
		case ($urandom_range(0, 5))
			0, 1, 2: begin
				add_text("0");
				add_crlf();
				add_crlf();
			end
			3: add_text("0");
			4: begin
				add_text("g");
				add_crlf();
			end
			default: begin
				cut = $urandom_range(1, msg.size());
				while (msg.size() > cut)
					void'(msg.pop_back());
			end
		endcase
	endfunction

	initial begin
		logic [23:0] cap;
		tracker = new();
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// whitespace, non-hex size end, extreme data bytes, trailer, missing size
		msg = '{CH_CR, CH_LF, CH_CR, CH_LF, CH_TAB, 8'h32, 8'h78, CH_CR, CH_LF,
			8'h00, 8'hFF, CH_CR, CH_LF, 8'h67};
		send_message();
		// saturated size gives too large
		msg = '{CH_CR, CH_LF, CH_CR, CH_LF, 8'h66, 8'h66, 8'h66, 8'h66, 8'h66, 8'h66,
			8'h66, CH_CR, CH_LF};
		send_message();
		// truncated in the header
		msg = '{8'h41};
		send_message();
		resp_valid <= 1'b0;

		for (int p = 0; p < 7; p++) begin
			wait_drained();
			case (p)
				0: cap = 24'hFFFFFF;
				1: cap = 24'd0;
				2: cap = 24'd1;
				3: cap = 24'd30;
				4: cap = CAP_RESET;
				5: cap = 24'($urandom_range(0, 60));
				default: cap = 24'($urandom_range(0, 24'hFFFFFF));
			endcase
			write_capacity(cap);
			calm = (p == 0);
			sent_count = 0;
			while (sent_count < PHASE_BYTES) begin
				make_message();
				send_message();
			end
			resp_valid <= 1'b0;
		end
		calm = 0;

		wait_drained();
		if (tracker.fail_count == 0)
			$display("http_chunked_body_decoder_unit verification clean");
		else
			$display("http_chunked_body_decoder_unit verification failed");
		$finish;
	end
endmodule

@@ sim.f @@
hdl/hcbd_pkg.sv
hdl/http_chunked_body_decoder_unit.sv
test/testbench.sv
